// ----- hw/rtl/tpc_pkg.sv -----
// ----------------------------------------------------------------------------
// tpc_pkg
// Shared types, codes and tables for the triangle plane clipper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package tpc_pkg;

    localparam int WORD_W         = 32;
    localparam int VERT_WORDS     = 8;   // x y z w, then four attribute words
    localparam int ATTR_BASE      = 4;
    localparam int PLANE_W        = 66;  // three floored products plus d
    localparam int CFG_IDX_W      = 3;
    localparam int ATTR_CNT_W     = 3;
    localparam int QUEUE_DEPTH    = 2;
    localparam int MAX_ATTRS_DEF  = 4;
    localparam int FRAC_BITS_DEF  = 16;

    localparam logic [CFG_IDX_W-1:0] REG_PLANE_A    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_B    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_C    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_D    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ATTR_COUNT = 3'd4;

    localparam logic [2:0] CASE_INSIDE  = 3'd0;
    localparam logic [2:0] CASE_OUTSIDE = 3'd1;
    localparam logic [2:0] CASE_IN_V0   = 3'd2;
    localparam logic [2:0] CASE_IN_V1   = 3'd3;
    localparam logic [2:0] CASE_IN_V2   = 3'd4;
    localparam logic [2:0] CASE_OUT_V0  = 3'd5;
    localparam logic [2:0] CASE_OUT_V1  = 3'd6;
    localparam logic [2:0] CASE_OUT_V2  = 3'd7;

    typedef logic [VERT_WORDS-1:0][WORD_W-1:0] vert_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] pos_x;
        logic signed [WORD_W-1:0] pos_y;
        logic signed [WORD_W-1:0] pos_z;
        logic signed [WORD_W-1:0] pos_w;
        logic signed [WORD_W-1:0] attr_0;
        logic signed [WORD_W-1:0] attr_1;
        logic signed [WORD_W-1:0] attr_2;
        logic signed [WORD_W-1:0] attr_3;
    } vtx_item_t;

    typedef struct packed {
        logic [2:0]               clip_case;
        logic                     vertex_valid;
        logic                     tri_select;
        logic signed [WORD_W-1:0] out_x;
        logic signed [WORD_W-1:0] out_y;
        logic signed [WORD_W-1:0] out_z;
        logic signed [WORD_W-1:0] out_w;
        logic signed [WORD_W-1:0] out_attr_0;
        logic signed [WORD_W-1:0] out_attr_1;
        logic signed [WORD_W-1:0] out_attr_2;
        logic signed [WORD_W-1:0] out_attr_3;
        logic                     run_last;
    } res_item_t;

    // one triangle with its plane values, front to back
    typedef struct packed {
        vert_t [2:0]              v;
        logic [2:0][PLANE_W-1:0]  f;
    } tri_rec_t;

    typedef struct packed {
        logic push;
        logic pop;
    } q_ctrl_t;

    typedef enum logic [1:0] {F_IDLE, F_EVAL, F_PUSH} front_state_t;
    typedef enum logic [2:0] {B_IDLE, B_SCAN, B_DIV, B_LERP, B_EMIT} back_state_t;

    typedef enum logic [2:0] {SRC_V0, SRC_V1, SRC_V2, SRC_I10, SRC_I21, SRC_I02} src_t;

    function automatic logic [2:0] emit_count(input logic [2:0] cc);
        logic [2:0] n;
        case (cc)
            CASE_OUTSIDE:                        n = 3'd1;
            CASE_OUT_V0, CASE_OUT_V1, CASE_OUT_V2: n = 3'd6;
            default:                             n = 3'd3;
        endcase
        return n;
    endfunction

    function automatic src_t emit_src(input logic [2:0] cc, input logic [2:0] idx);
        src_t s;
        s = SRC_V0;
        case (cc)
            CASE_INSIDE:
                case (idx)
                    3'd1:    s = SRC_V1;
                    3'd2:    s = SRC_V2;
                    default: s = SRC_V0;
                endcase
            CASE_IN_V0:
                case (idx)
                    3'd1:    s = SRC_I10;
                    3'd2:    s = SRC_I02;
                    default: s = SRC_V0;
                endcase
            CASE_IN_V1:
                case (idx)
                    3'd1:    s = SRC_V1;
                    3'd2:    s = SRC_I21;
                    default: s = SRC_I10;
                endcase
            CASE_IN_V2:
                case (idx)
                    3'd1:    s = SRC_I21;
                    3'd2:    s = SRC_V2;
                    default: s = SRC_I02;
                endcase
            CASE_OUT_V0:
                case (idx)
                    3'd1:    s = SRC_V1;
                    3'd2:    s = SRC_V2;
                    3'd3:    s = SRC_V2;
                    3'd4:    s = SRC_I02;
                    default: s = SRC_I10;
                endcase
            CASE_OUT_V1:
                case (idx)
                    3'd1:    s = SRC_I10;
                    3'd2:    s = SRC_V2;
                    3'd3:    s = SRC_V2;
                    3'd4:    s = SRC_I10;
                    3'd5:    s = SRC_I21;
                    default: s = SRC_V0;
                endcase
            CASE_OUT_V2:
                case (idx)
                    3'd1:    s = SRC_V1;
                    3'd2:    s = SRC_I21;
                    3'd3:    s = SRC_I21;
                    3'd4:    s = SRC_I02;
                    default: s = SRC_V0;
                endcase
            default: s = SRC_V0;
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/tpc_front.sv -----
// ----------------------------------------------------------------------------
// tpc_front
// Takes vertices, keeps the first two, evaluates the plane for each one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tpc_front #(
    parameter int FRAC_BITS = tpc_pkg::FRAC_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        vtx_valid,
    output logic                             vtx_stall,
    input  wire tpc_pkg::vtx_item_t          vtx,
    input  wire logic [tpc_pkg::WORD_W-1:0]  plane_a,
    input  wire logic [tpc_pkg::WORD_W-1:0]  plane_b,
    input  wire logic [tpc_pkg::WORD_W-1:0]  plane_c,
    input  wire logic [tpc_pkg::WORD_W-1:0]  plane_d,
    input  wire logic                        q_full,
    output logic                             q_push,
    output tpc_pkg::tri_rec_t                rec
);
    localparam int PW = tpc_pkg::PLANE_W;
    localparam int WW = tpc_pkg::WORD_W;

    tpc_pkg::front_state_t state_reg, state_next;
    logic [1:0]     slot_reg, slot_next;
    logic [1:0]     step_reg;
    tpc_pkg::vert_t cur_reg, v0_reg, v1_reg;
    logic [PW-1:0]  acc_reg, f0_reg, f1_reg, f2_reg;

    logic               accept;
    logic signed [WW-1:0]   coef, coord;
    logic signed [2*WW-1:0] prod, prod_fl;
    logic [PW-1:0]      term, acc_sum;

    assign accept = vtx_valid && !vtx_stall;

    always_comb
    begin
        case (step_reg)
            2'd0:    coef = $signed(plane_a);
            2'd1:    coef = $signed(plane_b);
            default: coef = $signed(plane_c);
        endcase
        coord   = $signed(cur_reg[step_reg]);
        prod    = coef * coord;
        prod_fl = prod >>> FRAC_BITS;
        term    = {{(PW-2*WW){prod_fl[2*WW-1]}}, prod_fl};
        if (step_reg == 2'd0)
            acc_sum = term;
        else if (step_reg == 2'd1)
            acc_sum = acc_reg + term;
        else
            acc_sum = acc_reg + term + {{(PW-WW){plane_d[WW-1]}}, plane_d};
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tpc_pkg::F_IDLE:
                if (accept)
                    state_next = tpc_pkg::F_EVAL;
            tpc_pkg::F_EVAL:
                if (step_reg == 2'd2)
                    state_next = (slot_reg == 2'd2) ? tpc_pkg::F_PUSH : tpc_pkg::F_IDLE;
            tpc_pkg::F_PUSH:
                if (!q_full)
                    state_next = tpc_pkg::F_IDLE;
            default: state_next = tpc_pkg::F_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        vtx_stall = (state_reg != tpc_pkg::F_IDLE);
        q_push    = (state_reg == tpc_pkg::F_PUSH) && !q_full;
    end

    always_comb
    begin
        slot_next = slot_reg;
        if (state_reg == tpc_pkg::F_PUSH && !q_full)
            slot_next = 2'd0;
        else if (state_reg == tpc_pkg::F_EVAL && step_reg == 2'd2 && slot_reg != 2'd2)
            slot_next = slot_reg + 2'd1;
    end

    assign rec.v = {cur_reg, v1_reg, v0_reg};
    assign rec.f = {f2_reg, f1_reg, f0_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tpc_pkg::F_IDLE;
            slot_reg  <= 2'd0;
            step_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
            if (state_reg == tpc_pkg::F_EVAL)
                step_reg <= (step_reg == 2'd2) ? 2'd0 : step_reg + 2'd1;
            else
                step_reg <= 2'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        // word 0 is x, words 4..7 the attributes
        if (accept)
            cur_reg <= {vtx.attr_3, vtx.attr_2, vtx.attr_1, vtx.attr_0,
                        vtx.pos_w, vtx.pos_z, vtx.pos_y, vtx.pos_x};
        if (state_reg == tpc_pkg::F_EVAL)
        begin
            acc_reg <= acc_sum;
            if (step_reg == 2'd2)
            begin
                case (slot_reg)
                    2'd0:
                    begin
                        v0_reg <= cur_reg;
                        f0_reg <= acc_sum;
                    end
                    2'd1:
                    begin
                        v1_reg <= cur_reg;
                        f1_reg <= acc_sum;
                    end
                    default: f2_reg <= acc_sum;
                endcase
            end
        end
    end
endmodule
`default_nettype wire

// ----- hw/rtl/tpc_queue.sv -----
// ----------------------------------------------------------------------------
// tpc_queue
// Short triangle queue between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tpc_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire tpc_pkg::q_ctrl_t  ctrl,
    input  wire tpc_pkg::tri_rec_t wr_rec,
    output tpc_pkg::tri_rec_t      rd_rec,
    output logic                   full,
    output logic                   empty
);
    localparam int DEPTH = tpc_pkg::QUEUE_DEPTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    tpc_pkg::tri_rec_t mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign full   = (count_reg == CW'(DEPTH));
    assign empty  = (count_reg == '0);
    assign rd_rec = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (ctrl.push)
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            if (ctrl.pop)
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            if (ctrl.push && !ctrl.pop)
                count_reg <= count_reg + 1'b1;
            else if (!ctrl.push && ctrl.pop)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
            mem[wr_ptr_reg] <= wr_rec;
    end
endmodule
`default_nettype wire

// ----- hw/rtl/tpc_back.sv -----
// ----------------------------------------------------------------------------
// tpc_back
// Cuts crossing edges (serial divide, serial lerp) and sends the results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tpc_back #(
    parameter int FRAC_BITS = tpc_pkg::FRAC_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire tpc_pkg::tri_rec_t               rec,
    input  wire logic                            q_empty,
    output logic                                 q_pop,
    input  wire logic [tpc_pkg::ATTR_CNT_W-1:0]  nattr,
    output logic                                 res_valid,
    input  wire logic                            res_stall,
    output tpc_pkg::res_item_t                   res
);
    localparam int PW  = tpc_pkg::PLANE_W;
    localparam int WW  = tpc_pkg::WORD_W;
    localparam int NW  = tpc_pkg::VERT_WORDS;
    localparam int QW  = FRAC_BITS + 1;
    localparam int CNW = $clog2(FRAC_BITS + 2);
    localparam int LW  = WW + 1 + QW + 1;

    tpc_pkg::back_state_t state_reg, state_next;
    tpc_pkg::vert_t v_reg   [3];
    tpc_pkg::vert_t cut_reg [3];
    logic [2:0]      ins_reg;
    logic [2:0][PW-1:0] f_reg;
    logic [2:0]      cc_reg;
    logic [1:0]      e_reg;
    logic [PW+1:0]   r_reg;
    logic [PW:0]     den_reg;
    logic [QW-1:0]   q_reg, t_reg;
    logic [CNW-1:0]  cnt_reg;
    logic [2:0]      k_reg;
    logic [2:0]      idx_reg;
    logic            res_valid_reg;
    tpc_pkg::res_item_t res_reg;

    logic [1:0]      e_nx;
    logic            crosses, load;
    logic [2:0]      cc_new, ins_new;
    logic [PW-1:0]   mag_s, mag_e;
    logic [PW+1:0]   trial, trial_sub;
    logic            div_done, lerp_done, emit_last;
    logic [QW-1:0]   q_new;
    logic signed [WW:0]   diff;
    logic signed [LW-1:0] lprod, lprod_sh;
    logic [WW-1:0]   st_w, lerp_w;
    tpc_pkg::src_t   src;
    tpc_pkg::vert_t  sel;
    tpc_pkg::res_item_t item;

    function automatic logic [tpc_pkg::ATTR_CNT_W-1:0] ATTR_CNT_W_EXT(input int i);
        return tpc_pkg::ATTR_CNT_W'(i);
    endfunction

    assign e_nx    = (e_reg == 2'd2) ? 2'd0 : e_reg + 2'd1;
    assign crosses = ins_reg[e_reg] != ins_reg[e_nx];

    // classify the incoming triangle
    always_comb
    begin
        ins_new = {~rec.f[2][PW-1], ~rec.f[1][PW-1], ~rec.f[0][PW-1]};
        case (ins_new)
            3'b111:  cc_new = tpc_pkg::CASE_INSIDE;
            3'b000:  cc_new = tpc_pkg::CASE_OUTSIDE;
            3'b001:  cc_new = tpc_pkg::CASE_IN_V0;
            3'b010:  cc_new = tpc_pkg::CASE_IN_V1;
            3'b100:  cc_new = tpc_pkg::CASE_IN_V2;
            3'b110:  cc_new = tpc_pkg::CASE_OUT_V0;
            3'b101:  cc_new = tpc_pkg::CASE_OUT_V1;
            default: cc_new = tpc_pkg::CASE_OUT_V2;
        endcase
    end

    // divider: one quotient bit a cycle
    always_comb
    begin
        mag_s = f_reg[e_reg][PW-1] ? (~f_reg[e_reg] + 1'b1) : f_reg[e_reg];
        mag_e = f_reg[e_nx][PW-1] ? (~f_reg[e_nx] + 1'b1) : f_reg[e_nx];
        trial = (cnt_reg == '0) ? r_reg : {r_reg[PW:0], 1'b0};
        trial_sub = trial - {1'b0, den_reg};
        div_done  = (cnt_reg == CNW'(FRAC_BITS));
        if (trial >= {1'b0, den_reg})
            q_new = {q_reg[QW-2:0], 1'b1};
        else
            q_new = {q_reg[QW-2:0], 1'b0};
    end

    // lerp of one word a cycle
    always_comb
    begin
        st_w     = v_reg[e_reg][k_reg];
        diff     = $signed({v_reg[e_nx][k_reg][WW-1], v_reg[e_nx][k_reg]})
                 - $signed({st_w[WW-1], st_w});
        lprod    = diff * $signed({1'b0, t_reg});
        lprod_sh = lprod >>> FRAC_BITS;
        lerp_w   = st_w + lprod_sh[WW-1:0];
        lerp_done = (k_reg == 3'(NW-1));
    end

    // result assembly
    always_comb
    begin
        src = tpc_pkg::emit_src(cc_reg, idx_reg);
        case (src)
            tpc_pkg::SRC_V0:  sel = v_reg[0];
            tpc_pkg::SRC_V1:  sel = v_reg[1];
            tpc_pkg::SRC_V2:  sel = v_reg[2];
            tpc_pkg::SRC_I10: sel = cut_reg[0];
            tpc_pkg::SRC_I21: sel = cut_reg[1];
            tpc_pkg::SRC_I02: sel = cut_reg[2];
            default:          sel = v_reg[0];
        endcase
        for (int i = tpc_pkg::ATTR_BASE; i < NW; i++)
            if (ATTR_CNT_W_EXT(i - tpc_pkg::ATTR_BASE) >= nattr)
                sel[i] = '0;
        emit_last = (idx_reg == tpc_pkg::emit_count(cc_reg) - 3'd1);
        item.clip_case    = cc_reg;
        item.vertex_valid = (cc_reg != tpc_pkg::CASE_OUTSIDE);
        item.tri_select   = (idx_reg >= 3'd3);
        item.out_x        = sel[0];
        item.out_y        = sel[1];
        item.out_z        = sel[2];
        item.out_w        = sel[3];
        item.out_attr_0   = sel[4];
        item.out_attr_1   = sel[5];
        item.out_attr_2   = sel[6];
        item.out_attr_3   = sel[7];
        item.run_last     = emit_last;
        if (cc_reg == tpc_pkg::CASE_OUTSIDE)
        begin
            item.out_x = '0; item.out_y = '0; item.out_z = '0; item.out_w = '0;
            item.out_attr_0 = '0; item.out_attr_1 = '0;
            item.out_attr_2 = '0; item.out_attr_3 = '0;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tpc_pkg::B_IDLE:
                if (!q_empty)
                    state_next = tpc_pkg::B_SCAN;
            tpc_pkg::B_SCAN:
                if (cc_reg == tpc_pkg::CASE_INSIDE || cc_reg == tpc_pkg::CASE_OUTSIDE)
                    state_next = tpc_pkg::B_EMIT;
                else if (crosses)
                    state_next = tpc_pkg::B_DIV;
                else if (e_reg == 2'd2)
                    state_next = tpc_pkg::B_EMIT;
            tpc_pkg::B_DIV:
                if (div_done)
                    state_next = tpc_pkg::B_LERP;
            tpc_pkg::B_LERP:
                if (lerp_done)
                    state_next = (e_reg == 2'd2) ? tpc_pkg::B_EMIT : tpc_pkg::B_SCAN;
            tpc_pkg::B_EMIT:
                if (load && emit_last)
                    state_next = tpc_pkg::B_IDLE;
            default: state_next = tpc_pkg::B_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        q_pop = (state_reg == tpc_pkg::B_IDLE) && !q_empty;
        load  = (state_reg == tpc_pkg::B_EMIT) && (!res_valid_reg || !res_stall);
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tpc_pkg::B_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
                res_valid_reg <= 1'b1;
            else if (!res_stall)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            tpc_pkg::B_IDLE:
            begin
                for (int j = 0; j < 3; j++)
                    v_reg[j] <= rec.v[j];
                f_reg   <= rec.f;
                ins_reg <= ins_new;
                cc_reg  <= cc_new;
                e_reg   <= 2'd0;
                idx_reg <= 3'd0;
            end
            tpc_pkg::B_SCAN:
            begin
                r_reg   <= {2'b00, mag_s};
                den_reg <= {1'b0, mag_s} + {1'b0, mag_e};
                q_reg   <= '0;
                cnt_reg <= '0;
                k_reg   <= 3'd0;
                if (!crosses && e_reg != 2'd2)
                    e_reg <= e_nx;
            end
            tpc_pkg::B_DIV:
            begin
                q_reg   <= q_new;
                r_reg   <= (trial >= {1'b0, den_reg}) ? trial_sub : trial;
                cnt_reg <= cnt_reg + 1'b1;
                if (div_done)
                begin
                    if (den_reg == '0)
                        t_reg <= '0;
                    else if (q_new > (QW'(1) << FRAC_BITS))
                        t_reg <= QW'(1) << FRAC_BITS;
                    else
                        t_reg <= q_new;
                end
            end
            tpc_pkg::B_LERP:
            begin
                cut_reg[e_reg][k_reg] <= lerp_w;
                k_reg <= k_reg + 3'd1;
                if (lerp_done && e_reg != 2'd2)
                    e_reg <= e_nx;
            end
            tpc_pkg::B_EMIT:
                if (load)
                begin
                    res_reg <= item;
                    idx_reg <= idx_reg + 3'd1;
                end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

// ----- hw/rtl/triangle_plane_clipper.sv -----
// ----------------------------------------------------------------------------
// triangle_plane_clipper
// Clips triangles against one plane, emitting zero, one or two triangles.
// ----------------------------------------------------------------------------
// Usage:
//   vtx channel : one vertex item per handshake (valid high, stall low).
//                 Three items make a triangle; the first two are stored with their plane values.
//   res channel : one output vertex item per handshake; run_last marks the
//                 final item of a triangle. A fully outside triangle gives a
//                 single marker item with vertex_valid low.
//   cfg port    : cfg_we / cfg_index / cfg_data, written while idle.
// Throughput: the front accepts a vertex, then takes three steps through the
//   single plane multiplier, and takes no new vertex until it is done. A
//   triangle then waits in a two-entry queue for the back, which cuts each
//   crossing edge in the serial divider and then the serial lerp, and sends
//   one result item per cycle while the output is not stalled.
// Reset clears the vertex count, the queue and the output register; the
//   plane resets to z >= 0 with no attributes carried.
// A stalled result holds in the output register; the back pauses, the
//   queue fills and the front then stalls the vtx channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module triangle_plane_clipper #(
    parameter int MAX_ATTRS = tpc_pkg::MAX_ATTRS_DEF,
    parameter int FRAC_BITS = tpc_pkg::FRAC_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           vtx_valid,
    output logic                                vtx_stall,
    input  wire tpc_pkg::vtx_item_t             vtx,
    output logic                                res_valid,
    input  wire logic                           res_stall,
    output tpc_pkg::res_item_t                  res,
    input  wire logic                           cfg_we,
    input  wire logic [tpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tpc_pkg::WORD_W-1:0]     cfg_data
);
    localparam int ACW = tpc_pkg::ATTR_CNT_W;

    // configuration registers
    logic [tpc_pkg::WORD_W-1:0] plane_a_reg, plane_b_reg, plane_c_reg, plane_d_reg;
    logic [ACW-1:0]             attr_count_reg;
    logic [ACW-1:0]             nattr;

    // attribute count saturates at the number the block carries
    assign nattr = (attr_count_reg > ACW'(MAX_ATTRS)) ? ACW'(MAX_ATTRS) : attr_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_a_reg    <= '0;
            plane_b_reg    <= '0;
            plane_c_reg    <= tpc_pkg::WORD_W'(1) << FRAC_BITS;
            plane_d_reg    <= '0;
            attr_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tpc_pkg::REG_PLANE_A:    plane_a_reg    <= cfg_data;
                tpc_pkg::REG_PLANE_B:    plane_b_reg    <= cfg_data;
                tpc_pkg::REG_PLANE_C:    plane_c_reg    <= cfg_data;
                tpc_pkg::REG_PLANE_D:    plane_d_reg    <= cfg_data;
                tpc_pkg::REG_ATTR_COUNT: attr_count_reg <= cfg_data[ACW-1:0];
                default: ;   // unknown index: ignored
            endcase
        end
    end

    tpc_pkg::tri_rec_t wr_rec, rd_rec;
    tpc_pkg::q_ctrl_t  q_ctrl;
    logic q_full, q_empty, q_push, q_pop;

    assign q_ctrl.push = q_push;
    assign q_ctrl.pop  = q_pop;

    // front: vertex intake and plane evaluation
    tpc_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .vtx_valid (vtx_valid),
        .vtx_stall (vtx_stall),
        .vtx       (vtx),
        .plane_a   (plane_a_reg),
        .plane_b   (plane_b_reg),
        .plane_c   (plane_c_reg),
        .plane_d   (plane_d_reg),
        .q_full    (q_full),
        .q_push    (q_push),
        .rec       (wr_rec)
    );

    // triangle queue decoupling the two halves
    tpc_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (q_ctrl),
        .wr_rec (wr_rec),
        .rd_rec (rd_rec),
        .full   (q_full),
        .empty  (q_empty)
    );

    // back: edge cuts and result sequencing
    tpc_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec       (rd_rec),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .nattr     (nattr),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );
endmodule
`default_nettype wire

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the triangle plane clipper: a directed table of
// vertex items, then random triangles, checked item by item against a
// predictor of the plane test, the edge cuts and the emit order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb;

    localparam int FB       = tpc_pkg::FRAC_BITS_DEF;
    localparam int N_RANDOM = 200;
    localparam logic [tpc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd5;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      vtx_valid = 1'b0;
    logic      vtx_stall;
    tpc_pkg::vtx_item_t vtx = '0;
    logic      res_valid;
    logic      res_stall = 1'b0;
    tpc_pkg::res_item_t res;
    logic      cfg_we = 1'b0;
    logic [tpc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [tpc_pkg::WORD_W-1:0]    cfg_data = '0;

    triangle_plane_clipper dut (
        .clk(clk), .rst_n(rst_n),
        .vtx_valid(vtx_valid), .vtx_stall(vtx_stall), .vtx(vtx),
        .res_valid(res_valid), .res_stall(res_stall), .res(res),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #6 clk = ~clk;

    // Run limit, far above the slowest correct run
    initial
    begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor state: its own copy of the plane, attribute count and the
    // two stored corners of the triangle being assembled.
    // ------------------------------------------------------------------
    longint    pl_a, pl_b, pl_c, pl_d;
    int        n_attr;
    tpc_pkg::vtx_item_t corner_q[2];
    int        corner_cnt;
    tpc_pkg::res_item_t clipped_q[$];
    int        n_bad;
    int        idle_pct;        // percent of cycles either side idles
    bit        hold_off;        // receiver long hold-off requested

    typedef longint vec_t[8];

    function automatic longint floor_sh(longint v);
        return v >>> FB;        // arithmetic shift is a floor
    endfunction

    function automatic longint plane_of(tpc_pkg::vtx_item_t v);
        return floor_sh(pl_a * longint'(v.pos_x)) + floor_sh(pl_b * longint'(v.pos_y))
             + floor_sh(pl_c * longint'(v.pos_z)) + pl_d;
    endfunction

    function automatic void to_vec(tpc_pkg::vtx_item_t v, output vec_t o);
        o[0] = v.pos_x;  o[1] = v.pos_y;  o[2] = v.pos_z;  o[3] = v.pos_w;
        o[4] = v.attr_0; o[5] = v.attr_1; o[6] = v.attr_2; o[7] = v.attr_3;
        for (int i = 0; i < 4; i++)
            if (i >= n_attr)
                o[4 + i] = 0;
    endfunction

    // cut point on edge st->en; plane values differ in sign
    function automatic void cut(vec_t st, vec_t en, longint fs, longint fe,
                                output vec_t o);
        longint unsigned num, den, q, r;
        num = fs < 0 ? -fs : fs;
        den = num + (fe < 0 ? -fe : fe);
        q = 0;
        if (den != 0)
        begin
            q = num / den;
            r = num % den;
            for (int i = 0; i < FB; i++)
            begin
                r = r << 1;
                q = q << 1;
                if (r >= den)
                begin
                    r = r - den;
                    q = q | 1;
                end
            end
        end
        if (q > (64'd1 << FB))
            q = 64'd1 << FB;
        for (int i = 0; i < 8; i++)
            o[i] = (i >= 4 && i - 4 >= n_attr) ? 0
                 : st[i] + floor_sh((en[i] - st[i]) * longint'(q));
    endfunction

    function automatic void push_vertex(logic [2:0] cc, vec_t v, bit tri_sel, bit last);
        tpc_pkg::res_item_t r;
        r.clip_case = cc;   r.vertex_valid = 1'b1; r.tri_select = tri_sel;
        r.out_x = v[0];     r.out_y = v[1];  r.out_z = v[2];  r.out_w = v[3];
        r.out_attr_0 = v[4]; r.out_attr_1 = v[5];
        r.out_attr_2 = v[6]; r.out_attr_3 = v[7];
        r.run_last = last;
        clipped_q.push_back(r);
    endfunction

    function automatic void predict_vertex(tpc_pkg::vtx_item_t in);
        vec_t v0, v1, v2, i10, i21, i02;
        longint f0, f1, f2;
        bit n0, n1, n2;
        tpc_pkg::res_item_t m;
        if (corner_cnt < 2)
        begin
            corner_q[corner_cnt] = in;
            corner_cnt++;
            return;
        end
        corner_cnt = 0;
        to_vec(corner_q[0], v0);
        to_vec(corner_q[1], v1);
        to_vec(in, v2);
        f0 = plane_of(corner_q[0]);
        f1 = plane_of(corner_q[1]);
        f2 = plane_of(in);
        n0 = f0 >= 0; n1 = f1 >= 0; n2 = f2 >= 0;
        if (n0 && n1 && n2)
        begin
            push_vertex(tpc_pkg::CASE_INSIDE, v0, 0, 0);
            push_vertex(tpc_pkg::CASE_INSIDE, v1, 0, 0);
            push_vertex(tpc_pkg::CASE_INSIDE, v2, 0, 1);
            return;
        end
        if (!n0 && !n1 && !n2)
        begin
            m = '0;
            m.clip_case = tpc_pkg::CASE_OUTSIDE;
            m.run_last = 1'b1;
            clipped_q.push_back(m);
            return;
        end
        i10 = '{default: 0}; i21 = '{default: 0}; i02 = '{default: 0};
        if (n0 != n1) cut(v0, v1, f0, f1, i10);
        if (n1 != n2) cut(v1, v2, f1, f2, i21);
        if (n2 != n0) cut(v2, v0, f2, f0, i02);
        if (n0 && !n1 && !n2)
        begin
            push_vertex(tpc_pkg::CASE_IN_V0, v0, 0, 0);
            push_vertex(tpc_pkg::CASE_IN_V0, i10, 0, 0);
            push_vertex(tpc_pkg::CASE_IN_V0, i02, 0, 1);
        end
        else if (!n0 && n1 && !n2)
        begin
            push_vertex(tpc_pkg::CASE_IN_V1, i10, 0, 0);
            push_vertex(tpc_pkg::CASE_IN_V1, v1, 0, 0);
            push_vertex(tpc_pkg::CASE_IN_V1, i21, 0, 1);
        end
        else if (!n0 && !n1 && n2)
        begin
            push_vertex(tpc_pkg::CASE_IN_V2, i02, 0, 0);
            push_vertex(tpc_pkg::CASE_IN_V2, i21, 0, 0);
            push_vertex(tpc_pkg::CASE_IN_V2, v2, 0, 1);
        end
        else if (!n0)
        begin
            push_vertex(tpc_pkg::CASE_OUT_V0, i10, 0, 0);
            push_vertex(tpc_pkg::CASE_OUT_V0, v1, 0, 0);
            push_vertex(tpc_pkg::CASE_OUT_V0, v2, 0, 0);
            push_vertex(tpc_pkg::CASE_OUT_V0, v2, 1, 0);
            push_vertex(tpc_pkg::CASE_OUT_V0, i02, 1, 0);
            push_vertex(tpc_pkg::CASE_OUT_V0, i10, 1, 1);
        end
        else if (!n1)
        begin
            push_vertex(tpc_pkg::CASE_OUT_V1, v0, 0, 0);
            push_vertex(tpc_pkg::CASE_OUT_V1, i10, 0, 0);
            push_vertex(tpc_pkg::CASE_OUT_V1, v2, 0, 0);
            push_vertex(tpc_pkg::CASE_OUT_V1, v2, 1, 0);
            push_vertex(tpc_pkg::CASE_OUT_V1, i10, 1, 0);
            push_vertex(tpc_pkg::CASE_OUT_V1, i21, 1, 1);
        end
        else
        begin
            push_vertex(tpc_pkg::CASE_OUT_V2, v0, 0, 0);
            push_vertex(tpc_pkg::CASE_OUT_V2, v1, 0, 0);
            push_vertex(tpc_pkg::CASE_OUT_V2, i21, 0, 0);
            push_vertex(tpc_pkg::CASE_OUT_V2, i21, 1, 0);
            push_vertex(tpc_pkg::CASE_OUT_V2, i02, 1, 0);
            push_vertex(tpc_pkg::CASE_OUT_V2, v0, 1, 1);
        end
    endfunction

    // ------------------------------------------------------------------
    // Result side: random stall, one long hold-off on request; every
    // accepted item is compared with the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (clipped_q.size() == 0)
            begin
                n_bad++;
                if (n_bad <= 10)
                    $display("unexpected result item %p", res);
            end
            else if (res !== clipped_q[0])
            begin
                n_bad++;
                if (n_bad <= 10)
                    $display("result mismatch: expected %p actual %p",
                             clipped_q[0], res);
                void'(clipped_q.pop_front());
            end
            else
                void'(clipped_q.pop_front());
        end
    end

    initial
    begin
        int k;
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                res_stall <= 1'b1;
                for (k = 0; k < 400; k++)
                    @(negedge clk);
                hold_off = 0;
            end
            res_stall <= ($urandom_range(99) < idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic send_vertex(tpc_pkg::vtx_item_t v);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            vtx_valid <= 1'b0;
            @(negedge clk);
        end
        vtx_valid <= 1'b1;
        vtx <= v;
        @(posedge clk);
        while (vtx_stall)
            @(posedge clk);
        predict_vertex(v);
        @(negedge clk);
        vtx_valid <= 1'b0;
    endtask

    task automatic write_reg(logic [tpc_pkg::CFG_IDX_W-1:0] idx,
                             logic [tpc_pkg::WORD_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            tpc_pkg::REG_PLANE_A:    pl_a = longint'(signed'(val));
            tpc_pkg::REG_PLANE_B:    pl_b = longint'(signed'(val));
            tpc_pkg::REG_PLANE_C:    pl_c = longint'(signed'(val));
            tpc_pkg::REG_PLANE_D:    pl_d = longint'(signed'(val));
            tpc_pkg::REG_ATTR_COUNT:
                n_attr = (val[2:0] > tpc_pkg::MAX_ATTRS_DEF) ? tpc_pkg::MAX_ATTRS_DEF
                                                              : val[2:0];
            default: ;
        endcase
    endtask

    // wait until every expectation has arrived, then let the back settle
    task automatic drain();
        while (clipped_q.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    function automatic tpc_pkg::vtx_item_t mk(int x, int y, int z, int a0);
        tpc_pkg::vtx_item_t v;
        v = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        v.pos_x = x; v.pos_y = y; v.pos_z = z; v.attr_0 = a0;
        return v;
    endfunction

    // small coordinates in -range..range units of one
    function automatic int coord(int span);
        return $signed($urandom_range(2 * span * 65536)) - span * 65536;
    endfunction

    // ------------------------------------------------------------------
    // Directed table: plane z >= 0, one triangle per clip case
    // ------------------------------------------------------------------
    localparam int ONE = 65536;
    int dir_z[24] = '{
         ONE,  ONE,  ONE,       // all inside
        -ONE, -ONE, -ONE,       // all outside
         ONE, -ONE, -ONE,       // v0 only inside
        -ONE,  ONE, -ONE,       // v1 only inside
        -ONE, -ONE,  ONE,       // v2 only inside
        -ONE,  ONE,  ONE,       // v0 only outside
         ONE, -ONE,  ONE,       // v1 only outside
         0,    0,   -1          // zero counts as inside; v2 outside
    };

    initial
    begin
        tpc_pkg::vtx_item_t v;
        tpc_pkg::res_item_t m;
        int n;
        pl_a = 0; pl_b = 0; pl_c = ONE; pl_d = 0; n_attr = 0;
        corner_cnt = 0; n_bad = 0; idle_pct = 28; hold_off = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset plane: an all-outside triangle has a fixed marker result
        for (int i = 0; i < 3; i++)
            send_vertex(mk(0, 0, -ONE, 0));
        m = '0;
        m.clip_case = tpc_pkg::CASE_OUTSIDE;
        m.run_last = 1'b1;
        if (clipped_q.size() != 1 || clipped_q[0] !== m)
        begin
            n_bad++;
            $display("marker prediction wrong");
        end
        drain();

        write_reg(tpc_pkg::REG_ATTR_COUNT, 32'd7);  // saturates to four
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);       // unused index, ignored
        for (int i = 0; i < 24; i++)
            send_vertex(mk($urandom, $urandom, dir_z[i], $urandom));
        drain();

        // extremes of the plane and the fields
        write_reg(tpc_pkg::REG_PLANE_A, 32'h7FFF_FFFF);
        write_reg(tpc_pkg::REG_PLANE_B, 32'h8000_0000);
        write_reg(tpc_pkg::REG_PLANE_C, 32'h0000_0001);
        write_reg(tpc_pkg::REG_PLANE_D, 32'h8000_0000);
        write_reg(tpc_pkg::REG_ATTR_COUNT, 32'd2);
        v = '1;
        send_vertex(v);
        v = {8{32'h8000_0000}};
        send_vertex(v);
        v = {8{32'h7FFF_FFFF}};
        send_vertex(v);
        drain();

        // random phases, several planes and attribute counts
        n = 0;
        for (int ph = 0; ph < 5; ph++)
        begin
            write_reg(tpc_pkg::REG_ATTR_COUNT, $urandom_range(ph == 0 ? 0 : 4, 4));
            write_reg(tpc_pkg::REG_PLANE_A, ph == 4 ? $urandom : coord(2));
            write_reg(tpc_pkg::REG_PLANE_B, ph == 4 ? $urandom : coord(2));
            write_reg(tpc_pkg::REG_PLANE_C, ph == 4 ? $urandom : coord(2));
            write_reg(tpc_pkg::REG_PLANE_D, ph == 4 ? $urandom : coord(3));
            idle_pct = (ph == 2) ? 0 : 28;   // one stretch with no idling
            if (ph == 3)
                hold_off = 1;                // back fills, front stalls
            for (int i = 0; i < N_RANDOM / 5; i++)
            begin
                if ($urandom_range(9) == 0)
                    v = {$urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom, $urandom};
                else
                    v = {coord(100), coord(100), coord(100), coord(100),
                         coord(1000), coord(1000), coord(1000), coord(1000)};
                send_vertex(v);
            end
            // finish the current triangle before changing the plane
            while (corner_cnt != 0)
                send_vertex({coord(50), coord(50), coord(50), coord(50),
                             coord(50), coord(50), coord(50), coord(50)});
            drain();
        end

        if (n_bad == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
`default_nettype wire
